FILE: hdl/lfhe_pkg.sv
// Shared types and constants of the LED fire heat engine.
package lfhe_pkg;

  localparam int CELLS_DEFAULT = 64;
  localparam int CELL_IDX_W    = 6;
  localparam int HEAT_W        = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [HEAT_W-1:0] COOLING_RESET      = 8'd40;
  localparam logic [HEAT_W-1:0] SPARK_CHANCE_RESET = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_COOLING      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARK_CHANCE = 2'd1;

  typedef enum logic [1:0] {
    ACT_COOL  = 2'd0,
    ACT_SPARK = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Work handed from the front to the back. OP_BLANK is a read of a cell
  // beyond the table, which answers black.
  typedef enum logic [1:0] {
    OP_COOL  = 2'd0,
    OP_SPARK = 2'd1,
    OP_READ  = 2'd2,
    OP_BLANK = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [CELL_IDX_W-1:0] addr;
    logic [HEAT_W-1:0]     amount;
  } work_t;

endpackage

FILE: hdl/lfhe_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lfhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lfhe_queue.sv
// Short FIFO that carries classified work from the front to the back.
module lfhe_queue import lfhe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_entry,
  input  logic  pop,
  output work_t pop_entry,
  output logic  empty,
  output logic  full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign empty     = (count == '0);
  assign full      = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/lfhe_front.sv
// Front end: input transfers, configuration registers, cursor and classification.
module lfhe_front import lfhe_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic [HEAT_W-1:0]      cool_amount,
  input  logic [HEAT_W-1:0]      spark_roll,
  input  logic [2:0]             spark_cell,
  input  logic [HEAT_W-1:0]      spark_amount,
  input  logic [CELL_IDX_W-1:0]  pixel_index,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [HEAT_W-1:0]      cfg_data,
  input  logic                   q_full,
  output logic                   q_push,
  output work_t                  q_entry
);

  localparam int AW         = $clog2(CELLS);
  localparam int LIM_W      = 10;
  localparam int LIM_SHIFT  = 20;
  localparam int LIM_RECIP  = ((1 << LIM_SHIFT) + CELLS - 1) / CELLS;
  localparam int LIM_RESET  = (int'(COOLING_RESET) * 10) / CELLS + 1;

  logic [AW-1:0]     cursor;
  logic [LIM_W-1:0]  limit;
  logic [HEAT_W-1:0] spark_chance;
  logic [11:0]       cool_x10;
  logic [31:0]       lim_prod;
  logic [LIM_W-1:0]  limit_next;
  logic              accept;
  logic              keep;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept && keep;

  // The cooldown limit cooling*10/CELLS+1 is worked out when cooling is written,
  // by a ceiling reciprocal that is exact over the whole 12-bit range.
  assign cool_x10   = 12'(cfg_data) * 12'd10;
  assign lim_prod   = 32'(cool_x10) * 32'(LIM_RECIP);
  assign limit_next = lim_prod[LIM_SHIFT +: LIM_W] + 1'b1;

  always_comb begin
    q_entry = '{op: OP_BLANK, addr: pixel_index, amount: spark_amount};
    keep    = 1'b0;
    case (action_t'(action))
      ACT_COOL: begin
        keep           = 1'b1;
        q_entry.op     = OP_COOL;
        q_entry.addr   = CELL_IDX_W'(cursor);
        q_entry.amount = (LIM_W'(cool_amount) < limit) ? cool_amount : limit[HEAT_W-1:0];
      end
      ACT_SPARK: begin
        keep         = (spark_roll < spark_chance) && (int'(spark_cell) < CELLS);
        q_entry.op   = OP_SPARK;
        q_entry.addr = CELL_IDX_W'(spark_cell);
      end
      ACT_READ: begin
        keep       = 1'b1;
        q_entry.op = (int'(pixel_index) < CELLS) ? OP_READ : OP_BLANK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      limit        <= LIM_W'(LIM_RESET);
      spark_chance <= SPARK_CHANCE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COOLING:      limit        <= limit_next;
          REG_SPARK_CHANCE: spark_chance <= cfg_data;
          default:          ;
        endcase
      end
      if (accept && (action_t'(action) == ACT_COOL)) begin
        cursor <= (cursor == AW'(CELLS - 1)) ? '0 : cursor + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/lfhe_back.sv
// Back end: heat table read-modify-write, diffusion and colour output register.
module lfhe_back import lfhe_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  work_t             q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HEAT_W-1:0] red,
  output logic [HEAT_W-1:0] green,
  output logic [HEAT_W-1:0] blue
);

  localparam int AW = $clog2(CELLS);

  localparam logic [HEAT_W-1:0] BAND_HIGH = 8'h80;
  localparam logic [HEAT_W-1:0] BAND_MID  = 8'h40;

  typedef enum logic [1:0] {
    ST_ISSUE = 2'b01,
    ST_EXEC  = 2'b10
  } state_t;

  typedef struct packed {
    logic [HEAT_W-1:0] r;
    logic [HEAT_W-1:0] g;
    logic [HEAT_W-1:0] b;
  } rgb_t;

  // t = round(h*191/255) = floor((382h+255)/510); the divide by 255 uses the
  // add-shift identity, exact for quotients far beyond 191.
  function automatic rgb_t heat_color(input logic [HEAT_W-1:0] h);
    logic [16:0] scaled;
    logic [15:0] half;
    logic [16:0] sum;
    logic [7:0]  t;
    logic [7:0]  ramp;
    rgb_t        c;
    scaled = 17'(h) * 17'd382 + 17'd255;
    half   = scaled[16:1];
    sum    = 17'(half) + 17'(half[15:8]) + 17'd1;
    t      = sum[15:8];
    ramp   = {t[5:0], 2'b00};
    if (t > BAND_HIGH) begin
      c = '{r: 8'hFF, g: 8'hFF, b: ramp};
    end else if (t > BAND_MID) begin
      c = '{r: 8'hFF, g: ramp, b: 8'h00};
    end else begin
      c = '{r: ramp, g: 8'h00, b: 8'h00};
    end
    return c;
  endfunction

  state_t            state;
  state_t            state_next;
  work_t             cur;
  logic [CELLS-1:0]  written;
  logic              rd_written;
  logic [HEAT_W-1:0] cooled_prev;
  logic [HEAT_W-1:0] cooled_prevprev;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [AW-1:0]     ram_waddr;
  logic [HEAT_W-1:0] ram_wdata;
  logic [HEAT_W-1:0] ram_rdata;

  logic [HEAT_W-1:0] heat;
  logic [HEAT_W-1:0] cooled;
  logic [9:0]        blend;
  logic [19:0]       blend_prod;
  logic [HEAT_W-1:0] diffused;
  logic              slot_free;
  logic              load_out;
  rgb_t              color;

  lfhe_ram #(
    .WIDTH(HEAT_W),
    .DEPTH(CELLS)
  ) u_heat_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Cells never written since reset read as cold.
  assign heat       = rd_written ? ram_rdata : '0;
  assign cooled     = (heat >= cur.amount) ? heat - cur.amount : '0;
  assign blend      = 10'(cooled_prev) + {1'b0, cooled_prevprev, 1'b0};
  assign blend_prod = 20'(blend) * 20'd683;
  assign diffused   = blend_prod[18:11];
  assign color      = (cur.op == OP_READ) ? heat_color(heat) : '0;
  assign slot_free  = !out_valid || !out_stall;
  assign ram_raddr  = q_entry.addr[AW-1:0];
  assign ram_waddr  = cur.addr[AW-1:0];

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = cooled;
    load_out   = 1'b0;
    case (state)
      ST_ISSUE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ram_re     = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cur.op)
          OP_COOL: begin
            ram_we     = 1'b1;
            ram_wdata  = (cur.addr >= CELL_IDX_W'(2)) ? diffused : cooled;
            state_next = ST_ISSUE;
          end
          OP_SPARK: begin
            ram_we     = 1'b1;
            ram_wdata  = heat + cur.amount;
            state_next = ST_ISSUE;
          end
          default: begin
            if (slot_free) begin
              load_out   = 1'b1;
              state_next = ST_ISSUE;
            end
          end
        endcase
      end
      default: state_next = ST_ISSUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_entry;
      rd_written <= written[ram_raddr];
    end
    if (load_out) begin
      red   <= color.r;
      green <= color.g;
      blue  <= color.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_ISSUE;
      written         <= '0;
      cooled_prev     <= '0;
      cooled_prevprev <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
      if ((state == ST_EXEC) && (cur.op == OP_COOL)) begin
        cooled_prevprev <= cooled_prev;
        cooled_prev     <= cooled;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/led_fire_heat_engine_core.sv
// Top level of the LED fire heat engine: front end, work queue and back end.
//
// The engine keeps a table of CELLS 8-bit heat cells for a fire animation. Each input
// transfer carries an action: cool the next cell in order (the cooldown is clamped to
// cooling*10/CELLS+1 and floored at zero, and cells from index 2 up take the blend
// (prev + 2*prevprev)/3 of the two cooled cells below them), add a spark to a low cell
// when the roll is below spark_chance, or read a cell out as an RGB fire colour. Only a
// read produces an output transfer; a read beyond the table answers black, a spark at a
// cell beyond the table and the unused action do nothing. The front end takes one input
// transfer per cycle into a four-entry queue and stalls only while that queue is full.
// The back end works each item in ST_ISSUE and then ST_EXEC, as set by the heat table
// RAM with its registered read: ST_ISSUE reads the cell, ST_EXEC modifies and writes it
// back or loads the colour into the output register. It takes no new item before it is
// through with the last one, and a colour waits behind a stalled output. Reset needs no
// clearing pass: one flag per cell marks it written, and an unwritten cell reads as
// zero. The configuration port is always ready; write cooling (index 0, reset 40) and
// spark_chance (index 1, reset 255) only while no item is in flight.
module led_fire_heat_engine_core import lfhe_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic [HEAT_W-1:0]      cool_amount,
  input  logic [HEAT_W-1:0]      spark_roll,
  input  logic [2:0]             spark_cell,
  input  logic [HEAT_W-1:0]      spark_amount,
  input  logic [CELL_IDX_W-1:0]  pixel_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [HEAT_W-1:0]      red,
  output logic [HEAT_W-1:0]      green,
  output logic [HEAT_W-1:0]      blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [HEAT_W-1:0]      cfg_data
);

  // Classified work travels through the queue as one struct per item.
  work_t push_entry;
  work_t pop_entry;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;

  lfhe_front #(
    .CELLS(CELLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .cool_amount (cool_amount),
    .spark_roll  (spark_roll),
    .spark_cell  (spark_cell),
    .spark_amount(spark_amount),
    .pixel_index (pixel_index),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  lfhe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .pop_entry (pop_entry),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end owns the heat table, the cooled-neighbour history and the
  // output register that parts it from the downstream stall.
  lfhe_back #(
    .CELLS(CELLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

FILE: hdl/lfhe_checker.sv
// Port-level checks of the LED fire heat engine, bound to its top level.
module lfhe_checker import lfhe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [HEAT_W-1:0] red,
  input logic [HEAT_W-1:0] green,
  input logic [HEAT_W-1:0] blue
);

  // A stalled output transfer keeps its colour.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled output colour changed");

  // Reset empties the queue and the output register.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue or output not clear after reset");

  // Blue only appears in the hottest band, where red and green are saturated.
  a_blue_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && (blue != 8'h00) |-> (red == 8'hFF) && (green == 8'hFF))
    else $error("blue ramp outside the hottest band");

  // Green only appears once red is saturated.
  a_green_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && (green != 8'h00) |-> (red == 8'hFF))
    else $error("green ramp without saturated red");

endmodule

bind led_fire_heat_engine_core lfhe_checker u_checker (.*);

FILE: test/tb_led_fire_heat_engine_core.sv
// Testbench for the LED fire heat engine core, checked against a behavioral heat table.
module tb_led_fire_heat_engine_core;
  import lfhe_pkg::*;

  localparam int CELLS        = CELLS_DEFAULT;
  // The work queue holds four items and the back end works them one at a time; the wait below
  // lets everything in flight clear before a register write.
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 40;

  // One input transfer, one field per port.
  typedef struct {
    action_t               act;
    logic [HEAT_W-1:0]     cool;
    logic [HEAT_W-1:0]     roll;
    logic [2:0]            target;
    logic [HEAT_W-1:0]     amount;
    logic [CELL_IDX_W-1:0] pixel;
  } fire_item_t;

  // One output transfer.
  typedef struct {
    logic [HEAT_W-1:0] red;
    logic [HEAT_W-1:0] green;
    logic [HEAT_W-1:0] blue;
  } rgb_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             action;
  logic [HEAT_W-1:0]      cool_amount;
  logic [HEAT_W-1:0]      spark_roll;
  logic [2:0]             spark_cell;
  logic [HEAT_W-1:0]      spark_amount;
  logic [CELL_IDX_W-1:0]  pixel_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [HEAT_W-1:0]      red;
  logic [HEAT_W-1:0]      green;
  logic [HEAT_W-1:0]      blue;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [HEAT_W-1:0]      cfg_data;

  // Our own copy of the engine state, advanced once per accepted input transfer.
  logic [HEAT_W-1:0]     model_heat [CELLS];
  logic [CELL_IDX_W-1:0] model_cursor;
  logic [HEAT_W-1:0]     model_prev;
  logic [HEAT_W-1:0]     model_prevprev;
  logic [HEAT_W-1:0]     model_cooling;
  logic [HEAT_W-1:0]     model_chance;

  // Colors that reads have asked for and that have not come out yet, oldest first.
  rgb_t expected_colours [$];

  int mismatches  = 0;
  int cycle_count = 0;

  // Idling knobs. The odds are percent per decision; quiet turns the random gaps and stalls off.
  bit quiet      = 1'b0;
  int gap_pct    = 15;
  int stall_pct  = 10;
  // A nonzero value asks the output side for one long hold-off; its value sets the length.
  int stall_hold = 0;

  led_fire_heat_engine_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .cool_amount  (cool_amount),
    .spark_roll   (spark_roll),
    .spark_cell   (spark_cell),
    .spark_amount (spark_amount),
    .pixel_index  (pixel_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost color ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Only the first few mismatches are printed so that a badly broken build does not flood
  // the log; all of them are counted.
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  // Fire palette: the heat is scaled to 0..191 with rounding, and the low six bits of that
  // form a ramp inside one of three bands (red rising, then green, then blue).
  function automatic rgb_t heat_to_rgb(input logic [HEAT_W-1:0] h);
    int   t;
    rgb_t c;
    t = (382 * int'(h) + 255) / 510;
    if (t > 'h80) begin
      c.red   = 8'd255;
      c.green = 8'd255;
      c.blue  = HEAT_W'((t & 'h3F) << 2);
    end else if (t > 'h40) begin
      c.red   = 8'd255;
      c.green = HEAT_W'((t & 'h3F) << 2);
      c.blue  = 8'd0;
    end else begin
      c.red   = HEAT_W'((t & 'h3F) << 2);
      c.green = 8'd0;
      c.blue  = 8'd0;
    end
    return c;
  endfunction

  // Advances the heat table by one accepted transfer and queues the color a read produces.
  task automatic heat_model_step(input fire_item_t it);
    int   limit;
    int   cd;
    int   h;
    int   cooled;
    rgb_t c;
    case (it.act)
      ACT_COOL: begin
        // The cooldown is clamped to the span limit and the cell never drops below zero.
        limit  = (int'(model_cooling) * 10) / CELLS + 1;
        cd     = (int'(it.cool) < limit) ? int'(it.cool) : limit;
        h      = int'(model_heat[model_cursor]);
        cooled = (cd > h) ? 0 : h - cd;
        // The two bottom cells keep their cooled heat; higher cells take the blend of the
        // two cooled cells just below them, weighted toward the lower one.
        if (model_cursor >= 2) begin
          model_heat[model_cursor] =
            HEAT_W'((int'(model_prev) + 2 * int'(model_prevprev)) / 3);
        end else begin
          model_heat[model_cursor] = HEAT_W'(cooled);
        end
        model_prevprev = model_prev;
        model_prev     = HEAT_W'(cooled);
        model_cursor   = (int'(model_cursor) == CELLS - 1) ? '0 : model_cursor + 1'b1;
      end
      ACT_SPARK: begin
        // The sum wraps in eight bits; a roll at or above the chance leaves the cell alone.
        if (it.roll < model_chance && int'(it.target) < CELLS) begin
          model_heat[it.target] = model_heat[it.target] + it.amount;
        end
      end
      ACT_READ: begin
        if (int'(it.pixel) < CELLS) begin
          c = heat_to_rgb(model_heat[it.pixel]);
        end else begin
          c.red   = 8'd0;
          c.green = 8'd0;
          c.blue  = 8'd0;
        end
        expected_colours.push_back(c);
      end
      default: begin
        // The unused action changes nothing and answers nothing.
      end
    endcase
  endtask

  // Every output transfer is compared with the oldest expected color, field by field.
  always @(posedge clk) begin : colour_check
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_colours.size() == 0) begin
        report_mismatch($sformatf("color %0d,%0d,%0d with none expected", red, green, blue));
      end else begin
        want = expected_colours.pop_front();
        if (red !== want.red) begin
          report_mismatch($sformatf("red %0d, expected %0d", red, want.red));
        end
        if (green !== want.green) begin
          report_mismatch($sformatf("green %0d, expected %0d", green, want.green));
        end
        if (blue !== want.blue) begin
          report_mismatch($sformatf("blue %0d, expected %0d", blue, want.blue));
        end
      end
    end
  end

  // Output side. Each pass drives out_stall once and then waits on the clock, so the
  // signal never gets two assignments in one time step. A long hold-off asked for by a test
  // is counted out here, independent of whatever the sender is doing meanwhile.
  initial begin : result_stall
    int n;
    forever begin
      if (stall_hold > 0) begin
        n          = stall_hold;
        stall_hold = 0;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        n          = $urandom_range(1, 15);
        out_stall <= 1'b1;
      end else begin
        n          = 1;
        out_stall <= 1'b0;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Random transfer. Fields the action does not use still carry noise. Roll and amount stay
  // in their usual ranges most of the time but sometimes use all eight bits, and the spark
  // target sometimes names cell 7, so that every bit of every field toggles.
  function automatic fire_item_t random_fire_item();
    fire_item_t it;
    int         pick;
    pick      = $urandom_range(0, 99);
    it.act    = (pick < 40) ? ACT_COOL : (pick < 65) ? ACT_SPARK :
                (pick < 95) ? ACT_READ : ACT_NOP;
    it.cool   = ($urandom_range(0, 2) == 0) ? HEAT_W'($urandom_range(0, 255))
                                            : HEAT_W'($urandom_range(0, 45));
    it.roll   = ($urandom_range(0, 9) == 0) ? HEAT_W'($urandom_range(0, 255))
                                            : HEAT_W'($urandom_range(0, 254));
    it.target = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    it.amount = ($urandom_range(0, 9) == 0) ? HEAT_W'($urandom_range(0, 255))
                                            : HEAT_W'($urandom_range(160, 254));
    // Reads lean toward the bottom of the table, where the heat actually is.
    it.pixel  = ($urandom_range(0, 1) == 0) ? CELL_IDX_W'($urandom_range(0, 15))
                                            : CELL_IDX_W'($urandom_range(0, CELLS - 1));
    return it;
  endfunction

  // Offers one transfer and returns at the edge where it is accepted. Valid is left high so
  // that a following transfer can go back to back; a gap, when one is drawn, lowers it first.
  task automatic send_item(input fire_item_t it);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= it.act;
    cool_amount  <= it.cool;
    spark_roll   <= it.roll;
    spark_cell   <= it.target;
    spark_amount <= it.amount;
    pixel_index  <= it.pixel;
    do @(posedge clk); while (in_stall);
    heat_model_step(it);
  endtask

  task automatic send_cool(input int amount);
    fire_item_t it;
    it      = random_fire_item();
    it.act  = ACT_COOL;
    it.cool = HEAT_W'(amount);
    send_item(it);
  endtask

  task automatic send_spark(input int target, input int amount, input int roll);
    fire_item_t it;
    it        = random_fire_item();
    it.act    = ACT_SPARK;
    it.target = 3'(target);
    it.amount = HEAT_W'(amount);
    it.roll   = HEAT_W'(roll);
    send_item(it);
  endtask

  task automatic send_read(input int pixel);
    fire_item_t it;
    it       = random_fire_item();
    it.act   = ACT_READ;
    it.pixel = CELL_IDX_W'(pixel);
    send_item(it);
  endtask

  // Stops offering and waits until every expected color has been seen.
  task automatic wait_for_colours();
    in_valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
  endtask

  // Cools and sparks leave no trace at the output, so after the last color the engine may
  // still be working; give it the drain time before touching the registers.
  task automatic set_fire_config(input logic [HEAT_W-1:0] cool, input logic [HEAT_W-1:0] chance);
    wait_for_colours();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_COOLING;
    cfg_data  <= cool;
    do @(posedge clk); while (!cfg_ready);
    model_cooling = cool;
    cfg_index <= REG_SPARK_CHANCE;
    cfg_data  <= chance;
    do @(posedge clk); while (!cfg_ready);
    model_chance = chance;
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked transfers at the reset settings: palette band edges, spark wrap, a roll
  // that loses, the unused action, the clamp at both ends and the bottom cells under cooling.
  task automatic test_directed_cases();
    fire_item_t it;
    send_read(0);                    // an untouched cell reads black
    send_spark(0, 254, 0);           // hottest usual spark with the lowest roll
    send_read(0);
    send_spark(0, 160, 254);         // wraps past 255; the highest usual roll still fires
    send_read(0);
    // Two sparks each build heats 86 and 87, the last value of the red band and the first
    // of the green band; 171 and 172 straddle the green to blue boundary.
    send_spark(3, 160, 100);
    send_spark(3, 182, 100);
    send_spark(4, 160, 50);
    send_spark(4, 183, 50);
    send_spark(5, 171, 1);
    send_spark(6, 172, 2);
    send_spark(1, 200, 255);         // a roll equal to the chance does nothing
    for (int p = 3; p <= 6; p++) begin
      send_read(p);
    end
    it     = random_fire_item();
    it.act = ACT_NOP;
    send_item(it);
    // Cells 0 and 1 keep their cooled heat; cell 2 takes the blend of the two below it.
    send_cool(255);
    send_cool(0);
    send_cool(7);
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(CELLS - 1);
  endtask

  // The output side holds off for a long stretch while reads keep coming, so the work queue
  // fills and the engine must stall its input. Afterwards the sender pauses until every
  // color is back before it goes on.
  task automatic test_output_backpressure();
    fire_item_t it;
    gap_pct    = 0;
    stall_hold = 300;
    repeat (40) begin
      it = random_fire_item();
      if ($urandom_range(0, 1) == 0) begin
        it.act = ACT_READ;
      end
      send_item(it);
    end
    wait_for_colours();
    repeat (10) send_item(random_fire_item());
    gap_pct = 15;
  endtask

  // Frames in the way the animation runs them: cool the whole column, throw a few sparks
  // at the bottom, then read back a handful of pixels.
  task automatic test_fire_frames(input int frames);
    set_fire_config(8'd60, 8'd180);
    repeat (frames) begin
      repeat (CELLS) send_cool($urandom_range(0, 12));
      repeat ($urandom_range(1, 3)) begin
        send_spark($urandom_range(0, 6), $urandom_range(160, 254), $urandom_range(0, 254));
      end
      repeat (16) begin
        send_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, CELLS - 1)
                                              : $urandom_range(0, 15));
      end
    end
  endtask

  // Random traffic under a series of register settings, the extremes of both among them.
  // Some phases run without idling on one side or the other.
  task automatic test_setting_sweep();
    logic [HEAT_W-1:0] cool_sets   [6];
    logic [HEAT_W-1:0] chance_sets [6];
    cool_sets   = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd128, HEAT_W'($urandom_range(0, 255))};
    chance_sets = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, HEAT_W'($urandom_range(0, 255))};
    for (int i = 0; i < 6; i++) begin
      set_fire_config(cool_sets[i], chance_sets[i]);
      gap_pct   = (i % 3 == 0) ? 0 : 20;
      stall_pct = (i % 3 == 1) ? 0 : 12;
      repeat (70) send_item(random_fire_item());
    end
    gap_pct   = 15;
    stall_pct = 10;
  endtask

  // Last stretch at full rate with both sides always ready, back at the reset settings.
  task automatic test_full_rate_tail();
    set_fire_config(COOLING_RESET, SPARK_CHANCE_RESET);
    quiet = 1'b1;
    repeat (70) send_item(random_fire_item());
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_NOP;
    cool_amount  <= '0;
    spark_roll   <= '0;
    spark_cell   <= '0;
    spark_amount <= '0;
    pixel_index  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_COOLING;
    cfg_data     <= '0;
    foreach (model_heat[i]) begin
      model_heat[i] = '0;
    end
    model_cursor   = '0;
    model_prev     = '0;
    model_prevprev = '0;
    model_cooling  = COOLING_RESET;
    model_chance   = SPARK_CHANCE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_fire_frames(4);
    test_setting_sweep();
    test_full_rate_tail();

    // Let the last colors come out, then watch a while longer for anything unexpected.
    wait_for_colours();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
